/* src/sse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants for the stack sort engine.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int DATA_W          = 32;
  localparam int POS_W           = 12;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [POS_W-1:0] POS_MAX = 12'd4095;

  // op field codes
  localparam logic OP_VALUE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH
  } sse_state_e;

  // one result word handed from the sequencer to the output register
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              last;
    logic              empty;
    logic              overflow;
  } sse_emit_t;

endpackage : sse_pkg
`default_nettype wire

/* src/sse_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule : sse_ram
`default_nettype wire

/* src/sse_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_seq
// Sequencer: one compare per step against the cached top of stack, pops
// through the stack RAM, pushes, and builds result words.
// ----------------------------------------------------------------------------
module sse_seq
  import sse_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic                           op_i,
  input  wire logic signed [DATA_W-1:0]       data_value_i,
  input  wire logic                           out_free_i,
  output      logic                           emit_valid_o,
  output      sse_emit_t                      emit_o,
  output      logic                           ram_wr_en_o,
  output      logic [$clog2(STACK_DEPTH)-1:0] ram_wr_addr_o,
  output      logic [DATA_W-1:0]              ram_wr_data_o,
  output      logic                           ram_rd_en_o,
  output      logic [$clog2(STACK_DEPTH)-1:0] ram_rd_addr_o,
  input  wire logic [DATA_W-1:0]              ram_rd_data_i
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  sse_state_e state_q, state_d;

  logic              op_q;
  logic [DATA_W-1:0] x_q;
  logic [DATA_W-1:0] top_q, top_d;
  logic [CW-1:0]     count_q, count_d;
  logic [POS_W-1:0]  wp_q, wp_d;
  logic              ovf_q, ovf_d;

  logic has_top, gt, is_flush, accept;
  logic pop_go, empty_go, push_go, push_ok, flush_done;

  // decode
  always_comb begin
    accept   = (state_q == ST_IDLE) && in_valid_i;
    is_flush = (op_q == OP_FLUSH);
    has_top  = (count_q != '0);
    gt       = $signed(x_q) > $signed(top_q);
    push_ok  = (count_q < DEPTH_C);
    pop_go   = (state_q == ST_CHECK) && out_free_i && has_top && (is_flush || gt);
    empty_go = (state_q == ST_CHECK) && out_free_i && !has_top && is_flush;
    push_go  = (state_q == ST_CHECK) && !is_flush && !(has_top && gt);
    flush_done = empty_go || (pop_go && is_flush && (count_q == ONE_C));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (flush_done || push_go) begin
          state_d = ST_IDLE;
        end else if (pop_go && (count_q >= TWO_C)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_CHECK;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    emit_valid_o  = pop_go || empty_go;
    emit_o.value    = empty_go ? '0 : top_q;
    emit_o.position = empty_go ? '0 : wp_q;
    emit_o.last     = flush_done;
    emit_o.empty    = empty_go;
    emit_o.overflow = ovf_q;

    ram_wr_en_o   = push_go && push_ok;
    ram_wr_addr_o = count_q[AW-1:0];
    ram_wr_data_o = x_q;
    ram_rd_en_o   = pop_go && (count_q >= TWO_C);
    ram_rd_addr_o = AW'(count_q - TWO_C);

    count_d = count_q;
    top_d   = top_q;
    wp_d    = wp_q;
    ovf_d   = ovf_q;
    if (pop_go) count_d = count_q - ONE_C;
    if (push_go && push_ok) begin
      count_d = count_q + ONE_C;
      top_d   = x_q;
    end
    if (push_go && !push_ok) ovf_d = 1'b1;
    if (state_q == ST_FETCH) top_d = ram_rd_data_i;
    if (emit_valid_o) wp_d = (wp_q == POS_MAX) ? wp_q : wp_q + 12'd1;
    if (flush_done) begin
      wp_d  = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      wp_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wp_q    <= wp_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (accept) begin
      op_q <= op_i;
      x_q  <= data_value_i;
    end
  end

  // checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid_o |-> out_free_i) else $error("result word emitted into busy output");
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_wr_en_o && ram_rd_en_o)) else $error("stack RAM read and write together");
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && emit_o.last) |=> (count_q == '0) && (wp_q == '0))
    else $error("flush left stack or position non-zero");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C) else $error("stack count beyond depth");
  a_fetch_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> $past(ram_rd_en_o)) else $error("fetch without read");

endmodule : sse_seq
`default_nettype wire

/* src/stack_sort_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_sort_engine_unit
// Single-stack sorter: pops smaller stacked values on each input, pushes the
// input, drains the stack on a flush.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o) takes one word: op_i selects a
//    value to sort or a flush. in_stall_o is high while a word is in work.
//  - Output channel (out_valid_o / out_stall_i) carries popped values with
//    their running position and last / empty_res / overflow flags.
//  - Timing: a word is taken in IDLE and decided in CHECK the next cycle. A
//    pop emits in CHECK, then FETCH reads the new top from the stack RAM
//    unless the pop emptied the stack. A result shows on the output in the
//    cycle after it is emitted. Each pop takes a CHECK step and, unless it
//    empties the stack, a FETCH step; the single RAM port and the one
//    comparator set this pace.
//  - Output stall: the result register holds its word; the sequencer waits
//    in CHECK until the register frees, and a new input can be taken while
//    a finished result still waits.
//  - Reset clears the sequencer, stack count, position and overflow flag;
//    the stack RAM is not cleared, there is no clearing pass.
// ----------------------------------------------------------------------------
module stack_sort_engine_unit
  import sse_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire logic                     op_i,
  input  wire logic signed [DATA_W-1:0] data_value_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      logic signed [DATA_W-1:0] out_value_o,
  output      logic [POS_W-1:0]         out_position_o,
  output      logic                     last_o,
  output      logic                     empty_res_o,
  output      logic                     overflow_o
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic              out_free;
  logic              emit_valid;
  sse_emit_t         emit;
  logic              out_valid_q;
  sse_emit_t         out_q;

  logic              ram_wr_en, ram_rd_en;
  logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
  logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

  // output register frees when empty or when the word is taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  sse_seq #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .data_value_i  (data_value_i),
    .out_free_i    (out_free),
    .emit_valid_o  (emit_valid),
    .emit_o        (emit),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data)
  );

  // stack storage; entries below the count are the only ones ever read
  sse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid) begin
      out_q <= emit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_q.value;
  assign out_position_o = out_q.position;
  assign last_o         = out_q.last;
  assign empty_res_o    = out_q.empty;
  assign overflow_o     = out_q.overflow;

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_q))
    else $error("stalled result word lost or changed");
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> last_o && (out_position_o == '0))
    else $error("empty flush result malformed");
  a_busy_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid |-> in_stall_o) else $error("result emitted while idle");

endmodule : stack_sort_engine_unit
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stack sort engine. A built-in stack predictor
// tracks every accepted word and queues the popped words it should produce;
// a monitor compares each output word against the oldest queued word.
// ----------------------------------------------------------------------------
module tb_top
  import sse_pkg::*;
();

  localparam int DEPTH     = STACK_DEPTH_DEF;
  localparam int MAX_NOTES = 10;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     op_i         = OP_VALUE;
  logic signed [DATA_W-1:0] data_value_i = '0;
  logic                     out_stall_i  = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] out_value_o;
  logic [POS_W-1:0]         out_position_o;
  logic                     last_o;
  logic                     empty_res_o;
  logic                     overflow_o;

  // idle / stall odds in percent, set to zero for the back-to-back test
  int unsigned in_idle_pct   = 29;
  int unsigned out_stall_pct = 29;

  // predictor state
  logic [DATA_W-1:0] model_stack [DEPTH];
  int unsigned       model_cnt;
  logic [POS_W-1:0]  model_pos;
  logic              model_ovf;

  // popped words still owed by the engine, oldest first
  sse_emit_t popped_words_q [$];

  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned flush_cnt;
  int unsigned drop_cnt;
  int unsigned peak_depth;
  int unsigned mismatch_cnt;

  always #10 clk_i = ~clk_i;

  stack_sort_engine_unit #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .data_value_i   (data_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_value_o    (out_value_o),
    .out_position_o (out_position_o),
    .last_o         (last_o),
    .empty_res_o    (empty_res_o),
    .overflow_o     (overflow_o)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Queue one popped word at the current position; position sticks at max.
  function automatic void queue_popped(input logic [DATA_W-1:0] val,
                                       input logic is_last, input logic is_empty);
    sse_emit_t w;
    w.value    = val;
    w.position = model_pos;
    w.last     = is_last;
    w.empty    = is_empty;
    w.overflow = model_ovf;
    popped_words_q.push_back(w);
    if (model_pos != POS_MAX) model_pos++;
  endfunction

  // One accepted input word: pop smaller entries then push, or drain on flush.
  function automatic void stack_sort_step(input logic op, input logic [DATA_W-1:0] val);
    if (op == OP_VALUE) begin
      // strict signed compare: an equal top stays put
      while (model_cnt > 0 && $signed(val) > $signed(model_stack[model_cnt-1])) begin
        model_cnt--;
        queue_popped(model_stack[model_cnt], 1'b0, 1'b0);
      end
      if (model_cnt < DEPTH) begin
        model_stack[model_cnt] = val;
        model_cnt++;
        if (model_cnt > peak_depth) peak_depth = model_cnt;
      end else begin
        // still full after the pops: word is dropped, flagged until flush
        model_ovf = 1'b1;
        drop_cnt++;
      end
    end else begin
      flush_cnt++;
      if (model_cnt == 0) begin
        model_pos = '0;
        queue_popped('0, 1'b1, 1'b1);
      end else begin
        while (model_cnt > 0) begin
          model_cnt--;
          queue_popped(model_stack[model_cnt], model_cnt == 0, 1'b0);
        end
      end
      model_pos = '0;
      model_ovf = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stall, compare each accepted word
  // --------------------------------------------------------------------------
  function automatic void check_popped_word();
    sse_emit_t w;
    logic      bad;
    if (popped_words_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_NOTES)
        $display("%0t: unexpected output word value=%0d pos=%0d last=%b empty=%b ovf=%b",
                 $realtime, out_value_o, out_position_o, last_o, empty_res_o, overflow_o);
    end else begin
      w = popped_words_q.pop_front();
      words_checked++;
      // an empty flush reports value zero
      bad = out_value_o !== w.value || out_position_o !== w.position ||
            last_o !== w.last || empty_res_o !== w.empty || overflow_o !== w.overflow;
      if (bad) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_NOTES) begin
          $display("%0t: mismatch exp value=%0d pos=%0d last=%b empty=%b ovf=%b",
                   $realtime, $signed(w.value), w.position, w.last, w.empty, w.overflow);
          $display("    got value=%0d pos=%0d last=%b empty=%b ovf=%b",
                   out_value_o, out_position_o, last_o, empty_res_o, overflow_o);
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_popped_word();
    out_stall_i <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Valid is only dropped inside an idle cycle, so a back-to-back word never
  // sees valid lowered and raised in the same step.
  task automatic send_word(input logic op, input logic [DATA_W-1:0] val);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i   <= 1'b0;
      op_i         <= 1'($urandom_range(1));
      data_value_i <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    data_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    stack_sort_step(op, val);
    words_sent++;
  endtask

  // Hold the sender off until every owed word has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (popped_words_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty flushes, signed extremes, equal values, a stack-sortable triple.
  task automatic test_directed_basics();
    send_word(OP_FLUSH, '0);
    send_word(OP_FLUSH, 32'hFFFF_FFFF);
    send_word(OP_VALUE, 32'sd0);
    send_word(OP_VALUE, -32'sd1);
    send_word(OP_VALUE, 32'h8000_0000);
    send_word(OP_VALUE, 32'h7FFF_FFFF);   // pops min, -1, 0
    send_word(OP_VALUE, 32'h7FFF_FFFF);   // equal: no pop
    send_word(OP_FLUSH, '0);
    send_word(OP_VALUE, 32'sd3);
    send_word(OP_VALUE, 32'sd1);
    send_word(OP_VALUE, 32'sd2);          // 3 1 2 comes out 1 2 3
    send_word(OP_FLUSH, '0);
    send_word(OP_VALUE, -32'sd1);
    send_word(OP_VALUE, 32'sd1);          // signed: 1 beats -1
    send_word(OP_VALUE, 32'h5555_5555);
    send_word(OP_VALUE, 32'hAAAA_AAAA);
    send_word(OP_VALUE, 32'h8000_0000);
    send_word(OP_FLUSH, '0);
    send_word(OP_FLUSH, '0);
  endtask

  // Fill the stack, drop words on a full stack, drain it in one burst.
  task automatic test_stack_full();
    for (int i = 0; i < DEPTH; i++) send_word(OP_VALUE, 32'(1000 - i));
    send_word(OP_VALUE, 32'(1000 - DEPTH + 1));   // equal to top: dropped
    send_word(OP_VALUE, -32'sd5);
    send_word(OP_VALUE, 32'h8000_0000);
    send_word(OP_VALUE, 32'sd2000);               // pops all entries
    send_word(OP_FLUSH, '0);
    send_word(OP_FLUSH, '0);                      // flag must be clear again
  endtask

  // Descending run, then rising values that pop a few entries each, then
  // two flushes. No idling on either side here: the long back-to-back stretch.
  task automatic test_back_to_back();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    for (int i = 0; i < 20; i++) send_word(OP_VALUE, 32'(100 - 3 * i));
    for (int i = 0; i < 10; i++) send_word(OP_VALUE, 32'(50 + 7 * i));
    send_word(OP_FLUSH, '0);
    send_word(OP_FLUSH, '0);
    in_idle_pct   = 29;
    out_stall_pct = 29;
  endtask

  // Mostly whole sequences ended by a flush, some long enough to overflow,
  // plus loose words with random op. One drain pause half way.
  task automatic test_random_sequences();
    int unsigned base;
    int unsigned len;
    bit          wide;
    bit          paused;
    base   = words_sent;
    paused = 1'b0;
    while (words_sent - base < 100) begin
      if (!paused && words_sent - base >= 50) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(99) < 80) begin
        len  = ($urandom_range(99) < 8) ? $urandom_range(60, 70) : $urandom_range(1, 10);
        wide = 1'($urandom_range(1));
        // narrow values make equal entries common
        repeat (len)
          send_word(OP_VALUE, wide ? 32'($urandom) : 32'(int'($urandom_range(15)) - 8));
        send_word(OP_FLUSH, $urandom);
      end else begin
        send_word(1'($urandom_range(1)), $urandom);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of tests and end of run
  // --------------------------------------------------------------------------
  initial begin
    model_cnt     = 0;
    model_pos     = '0;
    model_ovf     = 1'b0;
    words_sent    = 0;
    words_checked = 0;
    flush_cnt     = 0;
    drop_cnt      = 0;
    peak_depth    = 0;
    mismatch_cnt  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_stack_full();
    test_back_to_back();
    test_random_sequences();

    in_valid_i <= 1'b0;
    while (popped_words_q.size() != 0) @(posedge clk_i);
    // catch any stray word after the last owed one
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d input words and %0d checked output words over %0d flushes.",
             words_sent, words_checked, flush_cnt);
    $display("Stack reached depth %0d, %0d pushes dropped on a full stack, %0d mismatches.",
             peak_depth, drop_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #50_000_000;
    $display("Timeout with %0d output words still owed", popped_words_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
src/sse_pkg.sv
src/sse_ram.sv
src/sse_seq.sv
src/stack_sort_engine_unit.sv
sim/tb_top.sv
